// ===== src/gbn_pkg.sv =====
// Shared opcodes, result actions and field widths for the go-back-N endpoint.
`default_nettype none

package gbn_pkg;

    // Field widths of the stream words
    localparam int unsigned OPCODE_W  = 2;
    localparam int unsigned ACTION_W  = 3;
    localparam int unsigned FSEQ_W    = 3;
    localparam int unsigned FPAY_W    = 32;
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 48;

    // Input event kinds
    typedef enum logic [OPCODE_W-1:0] {
        OP_NEW     = 2'd0,
        OP_ARRIVE  = 2'd1,
        OP_CKERR   = 2'd2,
        OP_TIMEOUT = 2'd3
    } opcode_t;

    // Result kinds
    typedef enum logic [ACTION_W-1:0] {
        ACT_TRANSMIT = 3'd0,
        ACT_DELIVER  = 3'd1,
        ACT_RELEASE  = 3'd2,
        ACT_NONE     = 3'd3,
        ACT_REJECT   = 3'd4
    } action_t;

endpackage

`default_nettype wire

// ===== src/go_back_n_link_endpoint_top.sv =====
// Go-back-N sliding-window link endpoint with piggybacked acks and a frame store.
//
//   channel   dir  handshake          tuser          tdata
//   s_        in   s_tvalid/s_tready  opcode         payload, rx_seq, rx_ack
//   m_        out  m_tvalid/m_tready  action         seq, ack, payload, flags
//
// Each input word is latched, then handled: a new packet, a delivery or a status
// word yields one result word; an ack release or a timeout resend emits one word
// per cycle while the m_ side is not stalled, up to MAX_SEQUENCE words. A timeout
// first reads the oldest frame from the frame store before the first resend.
// Reset clears the sequence counters and the in-flight count; the frame store
// is not cleared. A stalled m_ side holds the sequencer with its result
// parked in the output register; s_tready is high only when the sequencer is idle.
`default_nettype none

module go_back_n_link_endpoint_top #(
    parameter int unsigned MAX_SEQUENCE  = 7,
    parameter int unsigned PAYLOAD_WIDTH = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata: payload[31:0], rx_seq[34:32], rx_ack[37:35], zero fill
    input  wire logic [gbn_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: opcode[1:0]
    input  wire logic [gbn_pkg::OPCODE_W-1:0]   s_tuser,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // m_tdata: out_seq[2:0], out_ack[5:3], out_payload[37:6],
    //          accept_more[38], in_flight[41:39], zero fill
    output logic [gbn_pkg::M_TDATA_W-1:0]       m_tdata,
    // m_tuser: action[2:0]
    output logic [gbn_pkg::ACTION_W-1:0]        m_tuser,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready
);

    import gbn_pkg::*;

    localparam int unsigned SEQ_W = (MAX_SEQUENCE < 2) ? 1 : $clog2(MAX_SEQUENCE + 1);
    localparam int unsigned CW    = (SEQ_W > FSEQ_W) ? SEQ_W : FSEQ_W;
    localparam logic [SEQ_W-1:0] SEQ_MAX = SEQ_W'(MAX_SEQUENCE);

    typedef logic [SEQ_W-1:0] seq_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RELEASE,
        ST_RESEND
    } state_t;

    // Circular test: a <= b < c
    function automatic logic in_win(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                    input logic [CW-1:0] c);
        return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

    function automatic seq_t seq_inc(input seq_t s);
        return (s >= SEQ_MAX) ? '0 : s + 1'b1;
    endfunction

    // Control and sequence state
    state_t  state_reg, state_next;
    seq_t    nts_reg, nts_next;
    seq_t    old_reg, old_next;
    seq_t    exp_reg, exp_next;
    seq_t    cnt_reg, cnt_next;
    seq_t    rem_reg, rem_next;

    // Latched input word
    opcode_t                op_reg;
    logic [FPAY_W-1:0]      pay_reg;
    logic [FSEQ_W-1:0]      rseq_reg;
    logic [FSEQ_W-1:0]      rack_reg;

    // Frame store and its registered read port
    logic [PAYLOAD_WIDTH-1:0] store_mem [0:MAX_SEQUENCE];
    logic [PAYLOAD_WIDTH-1:0] rd_data_reg;
    logic                     mem_we;

    // Output register
    logic                 out_valid_reg;
    action_t              out_action_reg;
    logic [FSEQ_W-1:0]    out_seq_reg;
    logic [FSEQ_W-1:0]    out_ack_reg;
    logic [FPAY_W-1:0]    out_pay_reg;
    logic                 out_last_reg;
    logic                 out_more_reg;
    logic [FSEQ_W-1:0]    out_flight_reg;

    // Result being emitted this cycle
    logic                 emit;
    action_t              e_action;
    logic [FSEQ_W-1:0]    e_seq;
    logic [FSEQ_W-1:0]    e_ack;
    logic [FPAY_W-1:0]    e_pay;
    logic                 e_last;
    seq_t                 e_cnt;

    logic                 out_free;
    logic                 deliver;
    logic                 rel_now;
    logic                 rel_after;
    logic [FSEQ_W-1:0]    ack_val;
    logic [PAYLOAD_WIDTH-1:0] wr_data;
    seq_t                 cnt_dec;
    seq_t                 old_inc;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    assign wr_data  = PAYLOAD_WIDTH'(pay_reg);
    assign ack_val  = FSEQ_W'((exp_reg == '0) ? SEQ_MAX : exp_reg - 1'b1);
    assign deliver  = (CW'(rseq_reg) == CW'(exp_reg));
    assign cnt_dec  = cnt_reg - 1'b1;
    assign old_inc  = seq_inc(old_reg);
    assign rel_now  = (cnt_reg != '0) && in_win(CW'(old_reg), CW'(rack_reg), CW'(nts_reg));
    assign rel_after = (cnt_dec != '0) && in_win(CW'(old_inc), CW'(rack_reg), CW'(nts_reg));

    // Sequencer: pick the result and the next state
    always_comb begin
        state_next = state_reg;
        nts_next   = nts_reg;
        old_next   = old_reg;
        exp_next   = exp_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        mem_we     = 1'b0;
        emit       = 1'b0;
        e_action   = ACT_NONE;
        e_seq      = '0;
        e_ack      = '0;
        e_pay      = '0;
        e_last     = 1'b1;
        e_cnt      = cnt_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    unique case (op_reg)
                        OP_NEW: begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                            if (cnt_reg < SEQ_MAX) begin
                                mem_we   = 1'b1;
                                e_action = ACT_TRANSMIT;
                                e_seq    = FSEQ_W'(nts_reg);
                                e_ack    = ack_val;
                                e_pay    = FPAY_W'(wr_data);
                                e_cnt    = cnt_reg + 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                                nts_next = seq_inc(nts_reg);
                            end else begin
                                e_action = ACT_REJECT;
                            end
                        end
                        OP_ARRIVE: begin
                            priority if (deliver) begin
                                emit       = 1'b1;
                                e_action   = ACT_DELIVER;
                                e_seq      = rseq_reg;
                                e_pay      = FPAY_W'(wr_data);
                                e_last     = !rel_now;
                                exp_next   = seq_inc(exp_reg);
                                state_next = rel_now ? ST_RELEASE : ST_IDLE;
                            end else if (rel_now) begin
                                state_next = ST_RELEASE;
                            end else begin
                                emit       = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        OP_CKERR: begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                        end
                        OP_TIMEOUT: begin
                            if (cnt_reg == '0) begin
                                emit       = 1'b1;
                                state_next = ST_IDLE;
                            end else begin
                                // rewind; the store read of the oldest frame starts now
                                nts_next   = old_reg;
                                rem_next   = cnt_reg;
                                state_next = ST_RESEND;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RELEASE: begin
                if (out_free) begin
                    emit     = 1'b1;
                    e_action = ACT_RELEASE;
                    e_seq    = FSEQ_W'(old_reg);
                    e_cnt    = cnt_dec;
                    e_last   = !rel_after;
                    cnt_next = cnt_dec;
                    old_next = old_inc;
                    if (!rel_after) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RESEND: begin
                if (out_free) begin
                    emit     = 1'b1;
                    e_action = ACT_TRANSMIT;
                    e_seq    = FSEQ_W'(nts_reg);
                    e_ack    = ack_val;
                    e_pay    = FPAY_W'(rd_data_reg);
                    e_last   = (rem_reg == seq_t'(1));
                    nts_next = seq_inc(nts_reg);
                    rem_next = rem_reg - 1'b1;
                    if (rem_reg == seq_t'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Frame store: write at the send pointer, read ahead at the next pointer
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[nts_reg] <= wr_data;
        end
        rd_data_reg <= store_mem[nts_next];
    end

    // Hold state and the output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            nts_reg       <= '0;
            old_reg       <= '0;
            exp_reg       <= '0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            nts_reg   <= nts_next;
            old_reg   <= old_next;
            exp_reg   <= exp_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Latch the input word and the result payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg   <= opcode_t'(s_tuser);
            pay_reg  <= s_tdata[FPAY_W-1:0];
            rseq_reg <= s_tdata[FPAY_W +: FSEQ_W];
            rack_reg <= s_tdata[FPAY_W+FSEQ_W +: FSEQ_W];
        end
        if (emit) begin
            out_action_reg <= e_action;
            out_seq_reg    <= e_seq;
            out_ack_reg    <= e_ack;
            out_pay_reg    <= e_pay;
            out_last_reg   <= e_last;
            out_more_reg   <= (e_cnt < SEQ_MAX);
            out_flight_reg <= FSEQ_W'(e_cnt);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_action_reg;
    assign m_tdata  = {6'd0, out_flight_reg, out_more_reg, out_pay_reg,
                       out_ack_reg, out_seq_reg};

endmodule

`default_nettype wire
